### src/rrot_pkg.sv
`timescale 1ns / 1ps
// Shared widths, stage counts and payload types for the rectangle overlap pipeline.
package rrot_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int ANGLE_WIDTH = 16;
   localparam int LEN_WIDTH   = COORD_WIDTH - 1;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;

   // Q16 sine/cosine span -65536..65536
   localparam int TRIG_WIDTH  = 18;

   localparam int TRIG_STAGES = 13;
   localparam int HALF_STAGES = 3;
   localparam int PIPE_STAGES = TRIG_STAGES + HALF_STAGES;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

   typedef enum logic [1:0] {
      QUAD_I,
      QUAD_II,
      QUAD_III,
      QUAD_IV
   } quad_type;

   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] dx_ab;
      logic signed [DIFF_WIDTH-1:0] dy_ab;
      logic signed [DIFF_WIDTH-1:0] dx_ba;
      logic signed [DIFF_WIDTH-1:0] dy_ba;
      logic [LEN_WIDTH-1:0]         a_len_one;
      logic [LEN_WIDTH-1:0]         a_len_two;
      logic [LEN_WIDTH-1:0]         b_len_one;
      logic [LEN_WIDTH-1:0]         b_len_two;
   } geo_type;

endpackage

### src/rrot_trig.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine of a binary angle by folded Horner series, Q16 results.
module rrot_trig import rrot_pkg::*; (
   input  logic                   clock,
   input  logic [TRIG_STAGES-1:0] load,
   input  logic [ANGLE_WIDTH-1:0] angle,
   output trig_type               sin_q16,
   output trig_type               cos_q16
);

   localparam int QW        = 30;
   localparam int SIN_STEPS = 4;
   localparam int COS_STEPS = 5;
   localparam int SIN_K [SIN_STEPS] = '{72, 42, 20, 6};
   localparam int COS_K [COS_STEPS] = '{90, 56, 30, 12, 2};
   localparam logic [QW:0]   ONE      = {1'b1, {QW{1'b0}}};
   localparam logic [QW-1:0] EIGHTH   = {2'b10, {(QW-2){1'b0}}};
   localparam int            RND_SH   = QW - 16;
   localparam logic [QW:0]   RND      = (QW+1)'(1) << (RND_SH - 1);

   logic [1:0]    quad_ff [0:11];
   logic          fold_ff [0:11];
   logic [QW-1:0] t_ff;
   logic [QW-1:0] x_ff    [1:9];
   logic [QW-1:0] x2_ff   [2:9];
   logic [QW-1:0] cos_p_ff [1:COS_STEPS-1];
   logic [QW-1:0] cos_q_ff [0:COS_STEPS-1];
   logic [QW-1:0] sin_p_ff [1:SIN_STEPS-1];
   logic [QW-1:0] sin_q_ff [0:SIN_STEPS-1];
   logic [QW:0]   sq_ff;
   logic [QW:0]   sin_hold_ff;
   trig_type      sin_ff, cos_ff;

   logic [31:0]   u;
   logic [QW-1:0] t_raw, t_fold;
   logic          fold0;
   logic [2*QW:0] x_prod, sq_prod;
   logic [2*QW-1:0] x2_prod;
   logic [QW:0]   sin_acc;

   // fold the offset inside a quadrant to at most an eighth turn
   assign u      = {angle, {(32-ANGLE_WIDTH){1'b0}}};
   assign t_raw  = u[QW-1:0];
   assign fold0  = t_raw > EIGHTH;
   assign t_fold = fold0 ? QW'(ONE - {1'b0, t_raw}) : t_raw;

   assign x_prod  = (2*QW+1)'(t_ff) * (2*QW+1)'(HALF_PI_Q30);
   assign x2_prod = (2*QW)'(x_ff[1]) * (2*QW)'(x_ff[1]);
   assign sin_acc = ONE - (QW+1)'(sin_q_ff[SIN_STEPS-1]);
   assign sq_prod = (2*QW+1)'(x_ff[9]) * (2*QW+1)'(sin_acc);

   genvar i;
   for (i = 0; i < COS_STEPS; i++) begin : g_step
      localparam int         KC = COS_K[i];
      localparam int         SC = QW + $clog2(KC);
      localparam logic [31:0] MC = 32'(((64'd1 << SC) / KC) + 64'd1);
      logic [QW-1:0]   pc;
      logic [QW+31:0]  qc_prod;

      if (i == 0) begin : g_c0
         assign pc = x2_ff[2];
      end else begin : g_cn
         logic [QW:0]   acc;
         logic [2*QW:0] pprod;
         assign acc   = ONE - (QW+1)'(cos_q_ff[i-1]);
         assign pprod = (2*QW+1)'(x2_ff[2*i+1]) * (2*QW+1)'(acc);
         always_ff @(posedge clock) begin
            if (load[2*i+2]) cos_p_ff[i] <= pprod[2*QW-1:QW];
         end
         assign pc = cos_p_ff[i];
      end

      // floor division by the series constant through a rounded-up reciprocal
      assign qc_prod = (QW+32)'(pc) * (QW+32)'(MC);
      always_ff @(posedge clock) begin
         if (load[2*i+3]) cos_q_ff[i] <= QW'(qc_prod >> SC);
      end

      if (i < SIN_STEPS) begin : g_sin
         localparam int          KS = SIN_K[i];
         localparam int          SS = QW + $clog2(KS);
         localparam logic [31:0] MS = 32'(((64'd1 << SS) / KS) + 64'd1);
         logic [QW-1:0]  ps;
         logic [QW+31:0] qs_prod;

         if (i == 0) begin : g_s0
            assign ps = x2_ff[2];
         end else begin : g_sn
            logic [QW:0]   acc;
            logic [2*QW:0] pprod;
            assign acc   = ONE - (QW+1)'(sin_q_ff[i-1]);
            assign pprod = (2*QW+1)'(x2_ff[2*i+1]) * (2*QW+1)'(acc);
            always_ff @(posedge clock) begin
               if (load[2*i+2]) sin_p_ff[i] <= pprod[2*QW-1:QW];
            end
            assign ps = sin_p_ff[i];
         end

         assign qs_prod = (QW+32)'(ps) * (QW+32)'(MS);
         always_ff @(posedge clock) begin
            if (load[2*i+3]) sin_q_ff[i] <= QW'(qs_prod >> SS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         quad_ff[0] <= u[31:30];
         fold_ff[0] <= fold0;
         t_ff       <= t_fold;
      end
      for (int k = 1; k <= 11; k++) begin
         if (load[k]) begin
            quad_ff[k] <= quad_ff[k-1];
            fold_ff[k] <= fold_ff[k-1];
         end
      end
      if (load[1]) x_ff[1] <= x_prod[2*QW-1:QW];
      for (int k = 2; k <= 9; k++) begin
         if (load[k]) x_ff[k] <= x_ff[k-1];
      end
      if (load[2]) x2_ff[2] <= x2_prod[2*QW-1:QW];
      for (int k = 3; k <= 9; k++) begin
         if (load[k]) x2_ff[k] <= x2_ff[k-1];
      end
      if (load[10]) sq_ff <= sq_prod[2*QW:QW];
      if (load[11]) sin_hold_ff <= sq_ff;
   end

   // round to Q16, undo the fold, place by quadrant
   logic [QW:0]   cq, s_sum, c_sum;
   logic [16:0]   s_mag, c_mag;
   trig_type      sp, cp, sin_in, cos_in;

   always_comb begin
      cq     = ONE - (QW+1)'(cos_q_ff[COS_STEPS-1]);
      s_sum  = sin_hold_ff + RND;
      c_sum  = cq + RND;
      s_mag  = fold_ff[11] ? c_sum[QW:RND_SH] : s_sum[QW:RND_SH];
      c_mag  = fold_ff[11] ? s_sum[QW:RND_SH] : c_sum[QW:RND_SH];
      sp     = $signed({1'b0, s_mag});
      cp     = $signed({1'b0, c_mag});
      case (quad_type'(quad_ff[11]))
         QUAD_I: begin
            sin_in = sp;
            cos_in = cp;
         end
         QUAD_II: begin
            sin_in = cp;
            cos_in = -sp;
         end
         QUAD_III: begin
            sin_in = -sp;
            cos_in = -cp;
         end
         default: begin
            sin_in = -cp;
            cos_in = sp;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[12]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q16 = sin_ff;
   assign cos_q16 = cos_ff;

endmodule

### src/rrot_half.sv
`timescale 1ns / 1ps
// One ordering of the separating-edge test: moved rectangle against reference edges.
module rrot_half import rrot_pkg::*; (
   input  logic                         clock,
   input  logic [HALF_STAGES-1:0]       load,
   input  trig_type                     ref_sin,
   input  trig_type                     ref_cos,
   input  trig_type                     rel_sin,
   input  trig_type                     rel_cos,
   input  logic signed [DIFF_WIDTH-1:0] dx,
   input  logic signed [DIFF_WIDTH-1:0] dy,
   input  logic [LEN_WIDTH-1:0]         ref_len_one,
   input  logic [LEN_WIDTH-1:0]         ref_len_two,
   input  logic [LEN_WIDTH-1:0]         mov_len_one,
   input  logic [LEN_WIDTH-1:0]         mov_len_two,
   output logic                         separated
);

   localparam int PW = TRIG_WIDTH + DIFF_WIDTH;
   localparam int SW = PW + 2;
   localparam int HW = LEN_WIDTH + 17;
   localparam int CW = SW + 2;

   logic signed [PW-1:0] cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   logic signed [PW-1:0] xa_ff, xb_ff, ya_ff, yb_ff;
   logic [LEN_WIDTH-1:0] h1_ff [0:1];
   logic [LEN_WIDTH-1:0] h2_ff [0:1];
   logic signed [SW-1:0] px_ff, py_ff, ex_ff, ey_ff;
   logic                 sep_ff;

   logic signed [LEN_WIDTH:0] ml1, ml2;
   logic signed [PW-1:0]      xa_abs, xb_abs, ya_abs, yb_abs;
   logic signed [HW-1:0]      hx, hy;
   logic signed [CW-1:0]      lo_x, hi_x, lo_y, hi_y;

   assign ml1 = $signed({1'b0, mov_len_one});
   assign ml2 = $signed({1'b0, mov_len_two});

   // corner extents: the farthest corner sits at |a| + |b| from the center
   assign xa_abs = xa_ff[PW-1] ? -xa_ff : xa_ff;
   assign xb_abs = xb_ff[PW-1] ? -xb_ff : xb_ff;
   assign ya_abs = ya_ff[PW-1] ? -ya_ff : ya_ff;
   assign yb_abs = yb_ff[PW-1] ? -yb_ff : yb_ff;

   assign hx = $signed({1'b0, h2_ff[1], 16'b0});
   assign hy = $signed({1'b0, h1_ff[1], 16'b0});

   assign lo_x = CW'(px_ff) + CW'(ex_ff) + CW'(hx);
   assign hi_x = CW'(px_ff) - CW'(ex_ff) - CW'(hx);
   assign lo_y = CW'(py_ff) + CW'(ey_ff) + CW'(hy);
   assign hi_y = CW'(py_ff) - CW'(ey_ff) - CW'(hy);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         cdx_ff   <= PW'(ref_cos) * PW'(dx);
         sdy_ff   <= PW'(ref_sin) * PW'(dy);
         cdy_ff   <= PW'(ref_cos) * PW'(dy);
         sdx_ff   <= PW'(ref_sin) * PW'(dx);
         xa_ff    <= PW'(rel_cos) * PW'(ml2);
         xb_ff    <= PW'(rel_sin) * PW'(ml1);
         ya_ff    <= PW'(rel_sin) * PW'(ml2);
         yb_ff    <= PW'(rel_cos) * PW'(ml1);
         h1_ff[0] <= ref_len_one;
         h2_ff[0] <= ref_len_two;
      end
      if (load[1]) begin
         px_ff    <= (SW'(cdx_ff) + SW'(sdy_ff)) <<< 1;
         py_ff    <= (SW'(cdy_ff) - SW'(sdx_ff)) <<< 1;
         ex_ff    <= SW'(xa_abs) + SW'(xb_abs);
         ey_ff    <= SW'(ya_abs) + SW'(yb_abs);
         h1_ff[1] <= h1_ff[0];
         h2_ff[1] <= h2_ff[0];
      end
      if (load[2]) begin
         sep_ff <= (lo_x <= 0) || (hi_x >= 0) || (lo_y <= 0) || (hi_y >= 0);
      end
   end

   assign separated = sep_ff;

endmodule

### src/rotated_rect_overlap_test_top.sv
`timescale 1ns / 1ps
// Top level of the oriented rectangle overlap test.
//
// Accepts one pair of oriented rectangles per cycle unless stalled, returns one
// overlap flag per pair, in order. Each rectangle is a signed Q16.8 center, two
// unsigned Q15.8 lengths and a 16-bit binary angle. The flag is 1 only if
// neither rectangle has an edge line with all four corners of the other at
// or beyond it, so touching rectangles report no overlap. Throughput is one
// transaction per clock when neither side stalls. The sine/cosine series
// takes a fold and a radian scaling multiply, a square, nine dependent
// multiply stages of the Horner evaluation and a rounding and quadrant
// placement stage; it is followed by three stages of frame rotation, corner
// extents and edge compares, and the output register. Each stage advances
// when the next one is empty or moving, so a stall on the result side lets
// empty stages keep filling before the request side is stalled; nothing is
// dropped or repeated.
module rotated_rect_overlap_test_top import rrot_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_first_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_center_y,
   input  logic [LEN_WIDTH-1:0]          req_first_length_one,
   input  logic [LEN_WIDTH-1:0]          req_first_length_two,
   input  logic [ANGLE_WIDTH-1:0]        req_first_angle,
   input  logic signed [COORD_WIDTH-1:0] req_second_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_center_y,
   input  logic [LEN_WIDTH-1:0]          req_second_length_one,
   input  logic [LEN_WIDTH-1:0]          req_second_length_two,
   input  logic [ANGLE_WIDTH-1:0]        req_second_angle,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_overlap
);

   logic [PIPE_STAGES-1:0] v_ff, v_in;
   logic [PIPE_STAGES:0]   load;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_overlap_ff;
   geo_type                geo_ff [0:TRIG_STAGES-1];
   geo_type                geo_in;

   logic [ANGLE_WIDTH-1:0] rel_ab, rel_ba;
   trig_type               sin_a, cos_a, sin_b, cos_b;
   trig_type               sin_ab, cos_ab, sin_ba, cos_ba;
   logic                   sep_ab, sep_ba;
   geo_type                geo_out;

   // Stage k may take new contents when empty or when its own contents move on.
   always_comb begin
      load[PIPE_STAGES] = ~rsp_valid_ff | ~rsp_stall;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         load[k] = ~v_ff[k] | load[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (load[k]) begin
            v_in[k] = (k == 0) ? req_valid : v_ff[k-1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
      rsp_valid_in = load[PIPE_STAGES] ? v_ff[PIPE_STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff         <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = ~load[0];

   // Center offsets for both orderings; lengths ride alongside the trig units.
   always_comb begin
      geo_in.dx_ab     = DIFF_WIDTH'(req_second_center_x) - DIFF_WIDTH'(req_first_center_x);
      geo_in.dy_ab     = DIFF_WIDTH'(req_second_center_y) - DIFF_WIDTH'(req_first_center_y);
      geo_in.dx_ba     = DIFF_WIDTH'(req_first_center_x) - DIFF_WIDTH'(req_second_center_x);
      geo_in.dy_ba     = DIFF_WIDTH'(req_first_center_y) - DIFF_WIDTH'(req_second_center_y);
      geo_in.a_len_one = req_first_length_one;
      geo_in.a_len_two = req_first_length_two;
      geo_in.b_len_one = req_second_length_one;
      geo_in.b_len_two = req_second_length_two;
   end

   always_ff @(posedge clock) begin
      if (load[0]) geo_ff[0] <= geo_in;
      for (int k = 1; k < TRIG_STAGES; k++) begin
         if (load[k]) geo_ff[k] <= geo_ff[k-1];
      end
   end

   assign geo_out = geo_ff[TRIG_STAGES-1];

   // Relative angles wrap modulo a full turn.
   assign rel_ab = req_second_angle - req_first_angle;
   assign rel_ba = req_first_angle - req_second_angle;

   rrot_trig u_trig_a (
      .clock   (clock),
      .load    (load[TRIG_STAGES-1:0]),
      .angle   (req_first_angle),
      .sin_q16 (sin_a),
      .cos_q16 (cos_a)
   );

   rrot_trig u_trig_b (
      .clock   (clock),
      .load    (load[TRIG_STAGES-1:0]),
      .angle   (req_second_angle),
      .sin_q16 (sin_b),
      .cos_q16 (cos_b)
   );

   rrot_trig u_trig_ab (
      .clock   (clock),
      .load    (load[TRIG_STAGES-1:0]),
      .angle   (rel_ab),
      .sin_q16 (sin_ab),
      .cos_q16 (cos_ab)
   );

   rrot_trig u_trig_ba (
      .clock   (clock),
      .load    (load[TRIG_STAGES-1:0]),
      .angle   (rel_ba),
      .sin_q16 (sin_ba),
      .cos_q16 (cos_ba)
   );

   // Second rectangle tested against the first one's edges.
   rrot_half u_half_ab (
      .clock       (clock),
      .load        (load[PIPE_STAGES-1:TRIG_STAGES]),
      .ref_sin     (sin_a),
      .ref_cos     (cos_a),
      .rel_sin     (sin_ab),
      .rel_cos     (cos_ab),
      .dx          (geo_out.dx_ab),
      .dy          (geo_out.dy_ab),
      .ref_len_one (geo_out.a_len_one),
      .ref_len_two (geo_out.a_len_two),
      .mov_len_one (geo_out.b_len_one),
      .mov_len_two (geo_out.b_len_two),
      .separated   (sep_ab)
   );

   // First rectangle tested against the second one's edges.
   rrot_half u_half_ba (
      .clock       (clock),
      .load        (load[PIPE_STAGES-1:TRIG_STAGES]),
      .ref_sin     (sin_b),
      .ref_cos     (cos_b),
      .rel_sin     (sin_ba),
      .rel_cos     (cos_ba),
      .dx          (geo_out.dx_ba),
      .dy          (geo_out.dy_ba),
      .ref_len_one (geo_out.b_len_one),
      .ref_len_two (geo_out.b_len_two),
      .mov_len_one (geo_out.a_len_one),
      .mov_len_two (geo_out.a_len_two),
      .separated   (sep_ba)
   );

   // Output register: hold while stalled, advance otherwise.
   always_ff @(posedge clock) begin
      if (load[PIPE_STAGES]) rsp_overlap_ff <= ~sep_ab & ~sep_ba;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

   // An accepted transaction always lands in the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   // The request side stalls only when the first stage is occupied.
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v_ff[0])
      else $error("request stalled with an empty first stage");

   // A finished item blocked by the output register is held, not dropped.
   a_last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[PIPE_STAGES-1] && !load[PIPE_STAGES] |=> v_ff[PIPE_STAGES-1])
      else $error("last pipeline stage lost its item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && (v_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

### bench/rotated_rect_overlap_test_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the oriented rectangle overlap pipeline.
module rotated_rect_overlap_test_top_test;
   import rrot_pkg::*;

   localparam longint Q30_ONE = 64'sd1 << 30;

   // Keeps the overlap flags still owed by the block, oldest first.
   class overlap_scoreboard;
      bit owed[$];
      int errors;

      function void note_request(bit flag);
         owed.push_back(flag);
      endfunction

      function void check_response(bit got);
         bit want;
         if (owed.size() == 0) begin
            $display("%0t: response with nothing owed, got overlap=%0b", $realtime, got);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (want !== got) begin
            $display("%0t: overlap mismatch, expected %0b actual %0b", $realtime, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_WIDTH-1:0] req_first_center_x = '0;
   logic signed [COORD_WIDTH-1:0] req_first_center_y = '0;
   logic [LEN_WIDTH-1:0]          req_first_length_one = '0;
   logic [LEN_WIDTH-1:0]          req_first_length_two = '0;
   logic [ANGLE_WIDTH-1:0]        req_first_angle = '0;
   logic signed [COORD_WIDTH-1:0] req_second_center_x = '0;
   logic signed [COORD_WIDTH-1:0] req_second_center_y = '0;
   logic [LEN_WIDTH-1:0]          req_second_length_one = '0;
   logic [LEN_WIDTH-1:0]          req_second_length_two = '0;
   logic [ANGLE_WIDTH-1:0]        req_second_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_overlap;

   overlap_scoreboard sb = new();
   int idle_pct  = 0;   // chance per cycle that the sender holds off
   int stall_pct = 0;   // chance per cycle that the receiver stalls

   always #2 clock = ~clock;

   rotated_rect_overlap_test_top dut (.*);

   // One Horner step of the Q30 series: 1 - x^2 * acc / k, truncating.
   function automatic longint horner(longint acc, longint x2, longint k);
      return Q30_ONE - ((x2 * acc) >>> 30) / k;
   endfunction

   // Q16 sine and cosine of a binary angle: fold to the first octant,
   // run both series, round to Q16, then unfold by octant and quadrant.
   function automatic void sincos_q16(input logic [ANGLE_WIDTH-1:0] ang,
                                      output longint s_o, output longint c_o);
      logic [31:0] u;
      quad_type    quad;
      longint      t, x, x2, a, sq, cq, s, c, tmp;
      bit          fold;
      u    = {ang, {(32-ANGLE_WIDTH){1'b0}}};
      quad = quad_type'(u[31:30]);
      t    = longint'(u[29:0]);
      fold = t > (64'sd1 << 29);
      if (fold) t = Q30_ONE - t;
      x  = (t * longint'(HALF_PI_Q30)) >>> 30;
      x2 = (x * x) >>> 30;
      a  = Q30_ONE;
      a  = horner(a, x2, 72);
      a  = horner(a, x2, 42);
      a  = horner(a, x2, 20);
      a  = horner(a, x2, 6);
      sq = (x * a) >>> 30;
      cq = Q30_ONE;
      cq = horner(cq, x2, 90);
      cq = horner(cq, x2, 56);
      cq = horner(cq, x2, 30);
      cq = horner(cq, x2, 12);
      cq = horner(cq, x2, 2);
      s  = (sq + 8192) >>> 14;
      c  = (cq + 8192) >>> 14;
      if (fold) begin
         tmp = s; s = c; c = tmp;
      end
      case (quad)
         QUAD_I:   begin s_o = s;  c_o = c;  end
         QUAD_II:  begin s_o = c;  c_o = -s; end
         QUAD_III: begin s_o = -s; c_o = -c; end
         default:  begin s_o = -c; c_o = s;  end
      endcase
   endfunction

   // True when no edge line of the reference rectangle separates the other.
   function automatic bit no_separating_edge(
         longint rcx, longint rcy, longint rl1, longint rl2, logic [ANGLE_WIDTH-1:0] rang,
         longint mcx, longint mcy, longint ml1, longint ml2, logic [ANGLE_WIDTH-1:0] mang);
      longint s, c, rs, rc, dx, dy, px, py, h1, h2, ox, oy, x, y;
      logic [ANGLE_WIDTH-1:0] rel;
      bit lo_x, hi_x, lo_y, hi_y;
      sincos_q16(rang, s, c);
      dx = mcx - rcx;
      dy = mcy - rcy;
      // rotate by minus the reference angle; scale by 2 so halves stay exact
      px = (c * dx + s * dy) * 2;
      py = (c * dy - s * dx) * 2;
      rel = mang - rang;
      sincos_q16(rel, rs, rc);
      h2 = rl2 * 65536;
      h1 = rl1 * 65536;
      lo_x = 1; hi_x = 1; lo_y = 1; hi_y = 1;
      for (int i = 0; i < 4; i++) begin
         ox = (i & 1) ? -ml2 : ml2;
         oy = (i & 2) ? -ml1 : ml1;
         x  = px + rc * ox - rs * oy;
         y  = py + rs * ox + rc * oy;
         if (!(x <= -h2)) lo_x = 0;
         if (!(x >= h2))  hi_x = 0;
         if (!(y <= -h1)) lo_y = 0;
         if (!(y >= h1))  hi_y = 0;
      end
      return !(lo_x || hi_x || lo_y || hi_y);
   endfunction

   // Note every accepted request and check every accepted response.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(
            no_separating_edge(longint'(req_first_center_x), longint'(req_first_center_y),
                               longint'(req_first_length_one),
                               longint'(req_first_length_two), req_first_angle,
                               longint'(req_second_center_x), longint'(req_second_center_y),
                               longint'(req_second_length_one),
                               longint'(req_second_length_two), req_second_angle) &&
            no_separating_edge(longint'(req_second_center_x), longint'(req_second_center_y),
                               longint'(req_second_length_one),
                               longint'(req_second_length_two), req_second_angle,
                               longint'(req_first_center_x), longint'(req_first_center_y),
                               longint'(req_first_length_one),
                               longint'(req_first_length_two), req_first_angle));
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_overlap);
   end

   // Receiver backpressure, redrawn every cycle.
   always @(negedge clock)
      rsp_stall <= (int'($urandom_range(99)) < stall_pct);

   // Present one transaction and hold it until the block takes it.
   task automatic send_pair(input int ax, ay, a1, a2, aa, bx, by, b1, b2, ba);
      while (int'($urandom_range(99)) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_first_center_x <= COORD_WIDTH'(ax);    req_first_center_y <= COORD_WIDTH'(ay);
      req_first_length_one <= LEN_WIDTH'(a1);    req_first_length_two <= LEN_WIDTH'(a2);
      req_first_angle <= ANGLE_WIDTH'(aa);
      req_second_center_x <= COORD_WIDTH'(bx);   req_second_center_y <= COORD_WIDTH'(by);
      req_second_length_one <= LEN_WIDTH'(b1);   req_second_length_two <= LEN_WIDTH'(b2);
      req_second_angle <= ANGLE_WIDTH'(ba);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Random pair: mostly rectangles placed near each other so both
   // orderings reach the edge compares, the rest full-range noise.
   task automatic send_random();
      int ax, ay, bx, by;
      int a1, a2, b1, b2;
      if ($urandom_range(99) < 70) begin
         ax = int'($urandom_range(4095)) - 2048; ay = int'($urandom_range(4095)) - 2048;
         bx = ax + int'($urandom_range(4095)) - 2048;
         by = ay + int'($urandom_range(4095)) - 2048;
         a1 = int'($urandom_range(3000)); a2 = int'($urandom_range(3000));
         b1 = int'($urandom_range(3000)); b2 = int'($urandom_range(3000));
      end else begin
         ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
         a1 = $urandom; a2 = $urandom; b1 = $urandom; b2 = $urandom;
      end
      send_pair(ax, ay, a1, a2, $urandom, bx, by, b1, b2, $urandom);
   endtask

   // Hold the sender until every owed response has arrived.
   task automatic drain(input int limit);
      int n;
      n = 0;
      while (sb.owed.size() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identical, touching, apart, degenerate and extreme pairs.
      send_pair(0, 0, 512, 512, 0, 0, 0, 512, 512, 0);
      send_pair(0, 0, 512, 512, 0, 512, 0, 512, 512, 0);       // touching edges
      send_pair(0, 0, 512, 512, 0, 511, 0, 512, 512, 0);
      send_pair(0, 0, 512, 512, 0, 0, 2048, 256, 256, 16'h2000);
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                  // zero lengths
      send_pair(0, 0, 0, 1024, 0, 0, 0, 1024, 0, 16'h4000);
      send_pair(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF,
                24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'h0000);
      send_pair(24'h800000, 24'h7FFFFF, 1, 1, 16'h8000,
                24'h7FFFFF, 24'h800000, 1, 1, 16'hC000);
      send_pair(100, -100, 700, 300, 16'h2000, -100, 100, 300, 700, 16'h2001);
      send_pair(100, -100, 700, 300, 16'h1FFF, 900, 0, 300, 700, 16'h6000);
      send_pair(0, 0, 23'h7FFFFF, 0, 16'h4000, 0, 0, 0, 23'h7FFFFF, 16'hC000);
      send_pair(-5000, 3000, 2000, 100, 16'hA000, -4000, 3500, 100, 2000, 16'hE000);
      send_pair(0, 0, 1000, 1000, 16'h8000, 1000, 1000, 1000, 1000, 16'h8000);
      send_pair(0, 0, 1000, 1000, 16'h2000, 1500, 0, 1000, 1000, 16'h2000);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         for (int i = 0; i < 325; i++) begin
            send_random();
            if (phase == 3 && i == 160) begin
               drop_valid();
               drain(100000);
            end
         end
      end
      drop_valid();
      stall_pct = 0;
      drain(100000);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("** rotated_rect_overlap_test_top: PASSED **");
      else begin
         if (sb.owed.size() != 0)
            $display("%0t: %0d responses never arrived", $realtime, sb.owed.size());
         $display("** rotated_rect_overlap_test_top: FAILED **");
      end
      $finish;
   end

   // Guard against a hung pipeline.
   initial begin
      #4000000;
      $display("** rotated_rect_overlap_test_top: FAILED **");
      $finish;
   end
endmodule
